[rtl/atilt_pkg.sv]
// Package for the accelerometer tilt angle block: item types, CORDIC arctangent table
// and angle constants. Depends on nothing; used by accel_tilt_angle.
package atilt_pkg;

   // One input item: the three raw register words.
   typedef struct packed {
      logic [15:0] x_word;
      logic [15:0] y_word;
      logic [15:0] z_word;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [14:0] tilt_angle;
      logic        zero_vector;
   } rsp_type;

   // Widths of the datapath.
   localparam int COMP_W  = 14;   // sign-extended component
   localparam int SUM_W   = 28;   // x*x + y*y
   localparam int ROOT_W  = 30;   // floor(sqrt(sum * 2^32))
   localparam int REM_W   = 32;   // square-root remainder
   localparam int VEC_W   = 34;   // CORDIC X and Y
   localparam int ACC_W   = 36;   // angle accumulator, radians * 2^32

   localparam int ATAN_LEN = 24;

   localparam logic signed [ACC_W-1:0] PI_Q32      = 36'sd13493037705;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
   localparam logic [14:0]             ANGLE_MAX   = 15'h7FFF;

   // Rounded atan(2^-i) * 2^32.
   localparam logic signed [ACC_W-1:0] ATAN_Q32 [ATAN_LEN] = '{
      36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
      36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
      36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
      36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
      36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
      36'sd4096,       36'sd2048,       36'sd1024,       36'sd512
   };

endpackage

[rtl/accel_tilt_angle.sv]
// Top level of the accelerometer tilt angle block: pipelined square root and CORDIC
// arctangent. Depends on atilt_pkg.
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+---------------------------------
//   input   | req_valid, req_ready, req_data | x_word, y_word, z_word
//   result  | rsp_valid, rsp_ready, rsp_data | tilt_angle, zero_vector
//
// One item enters in every cycle while the result register is not stalled. Each item
// passes through the decode, square and sum stages, the 30-stage square root with a
// stage for each root bit, the quadrant set-up, a CORDIC stage for each step and the
// rounding stage. Reset clears only the stage valid bits. A stalled result register holds
// the whole pipeline, so no item is lost or repeated.
module accel_tilt_angle #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  atilt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output atilt_pkg::rsp_type rsp_data
);

   localparam int NSTEP = (CORDIC_STEPS < atilt_pkg::ATAN_LEN) ?
                          CORDIC_STEPS : atilt_pkg::ATAN_LEN;
   localparam int NROOT = atilt_pkg::ROOT_W;
   localparam int NSTG  = NROOT + NSTEP + 5;
   localparam int CW    = atilt_pkg::COMP_W;
   localparam int VW    = atilt_pkg::VEC_W;
   localparam int AW    = atilt_pkg::ACC_W;

   logic adv;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;

   // The pipeline moves whenever the result register is empty or being taken.
   assign adv       = !vld_ff[NSTG-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NSTG-1];
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Decode stage: drop the two low bits, keeping the sign.
   logic signed [CW-1:0] dx_ff, dy_ff, dz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= $signed(req_data.x_word[15:2]);
         dy_ff <= $signed(req_data.y_word[15:2]);
         dz_ff <= $signed(req_data.z_word[15:2]);
      end
   end

   // Square stage.
   logic signed [2*CW-1:0] xsq_w, ysq_w;
   logic [26:0]            xsq_ff, ysq_ff;
   logic signed [CW-1:0]   sz_ff;
   logic                   szv_ff;
   assign xsq_w = dx_ff * dx_ff;
   assign ysq_w = dy_ff * dy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xsq_ff <= xsq_w[26:0];
         ysq_ff <= ysq_w[26:0];
         sz_ff  <= dz_ff;
         szv_ff <= (dx_ff == '0) && (dy_ff == '0) && (dz_ff == '0);
      end
   end

   // Square root stages, one root bit each; index 0 is loaded by the sum stage.
   logic [atilt_pkg::SUM_W-1:0]  s_ff   [NROOT+1];
   logic [atilt_pkg::REM_W-1:0]  rem_ff [NROOT+1];
   logic [NROOT-1:0]             q_ff   [NROOT+1];
   logic signed [CW-1:0]         rz_ff  [NROOT+1];
   logic                         rzv_ff [NROOT+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0]   <= {1'b0, xsq_ff} + {1'b0, ysq_ff};
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         rz_ff[0]  <= sz_ff;
         rzv_ff[0] <= szv_ff;
      end
   end

   for (genvar k = 0; k < NROOT; k++) begin : g_root
      localparam int J = NROOT - 1 - k;
      logic [1:0]                  pair;
      logic [atilt_pkg::REM_W-1:0] rsh, trial;
      if (J >= 16) begin : g_hi
         assign pair = s_ff[k][2*J-31 -: 2];
      end else begin : g_lo
         assign pair = 2'b00;
      end
      assign rsh   = {rem_ff[k][atilt_pkg::REM_W-3:0], pair};
      assign trial = {q_ff[k], 2'b01};
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rsh >= trial) begin
               rem_ff[k+1] <= rsh - trial;
               q_ff[k+1]   <= {q_ff[k][NROOT-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= rsh;
               q_ff[k+1]   <= {q_ff[k][NROOT-2:0], 1'b0};
            end
            s_ff[k+1]   <= s_ff[k];
            rz_ff[k+1]  <= rz_ff[k];
            rzv_ff[k+1] <= rzv_ff[k];
         end
      end
   end

   // Quadrant set-up: rotate by -pi/2 when -z is negative.
   logic signed [VW-1:0] cx_ff  [NSTEP+1];
   logic signed [VW-1:0] cy_ff  [NSTEP+1];
   logic signed [AW-1:0] acc_ff [NSTEP+1];
   logic                 czv_ff [NSTEP+1];
   logic signed [VW-1:0] u_w, r_w;
   assign u_w = (-{{(VW-CW){rz_ff[NROOT][CW-1]}}, rz_ff[NROOT]}) <<< 16;
   assign r_w = $signed({{(VW-NROOT){1'b0}}, q_ff[NROOT]});

   always_ff @(posedge clock) begin
      if (adv) begin
         if (u_w < 0) begin
            cx_ff[0]  <= r_w;
            cy_ff[0]  <= -u_w;
            acc_ff[0] <= atilt_pkg::HALF_PI_Q32;
         end else begin
            cx_ff[0]  <= u_w;
            cy_ff[0]  <= r_w;
            acc_ff[0] <= '0;
         end
         czv_ff[0] <= rzv_ff[NROOT];
      end
   end

   // CORDIC vectoring steps, one per stage.
   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic signed [VW-1:0] sx, sy;
      assign sx = cy_ff[i] >>> i;
      assign sy = cx_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (cy_ff[i] >= 0) begin
               cx_ff[i+1]  <= cx_ff[i] + sx;
               cy_ff[i+1]  <= cy_ff[i] - sy;
               acc_ff[i+1] <= acc_ff[i] + atilt_pkg::ATAN_Q32[i];
            end else begin
               cx_ff[i+1]  <= cx_ff[i] - sx;
               cy_ff[i+1]  <= cy_ff[i] + sy;
               acc_ff[i+1] <= acc_ff[i] - atilt_pkg::ATAN_Q32[i];
            end
            czv_ff[i+1] <= czv_ff[i];
         end
      end
   end

   // Clamp to [0, pi], round to the output scale and saturate.
   logic signed [AW-1:0] clamp_w;
   logic [34:0]          rnd_w, ang_w;
   always_comb begin
      if (acc_ff[NSTEP] < 0) begin
         clamp_w = '0;
      end else if (acc_ff[NSTEP] > atilt_pkg::PI_Q32) begin
         clamp_w = atilt_pkg::PI_Q32;
      end else begin
         clamp_w = acc_ff[NSTEP];
      end
      rnd_w = {1'b0, clamp_w[33:0]} + (35'd1 << (31 - ANGLE_FRAC_BITS));
      ang_w = rnd_w >> (32 - ANGLE_FRAC_BITS);
   end

   atilt_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.zero_vector <= czv_ff[NSTEP];
         if (czv_ff[NSTEP]) begin
            rsp_ff.tilt_angle <= '0;
         end else if (ang_w > 35'(atilt_pkg::ANGLE_MAX)) begin
            rsp_ff.tilt_angle <= atilt_pkg::ANGLE_MAX;
         end else begin
            rsp_ff.tilt_angle <= ang_w[14:0];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
